### src/rcb_pkg.sv
package rcb_pkg;

  localparam int unsigned NumLetters = 26;

  localparam logic [4:0] LastLetter = 5'(NumLetters - 1);

  // input item function codes
  localparam logic [1:0] FuncEncipher = 2'd0;
  localparam logic [1:0] FuncLoad     = 2'd1;
  localparam logic [1:0] FuncRestart  = 2'd2;
  localparam logic [1:0] FuncUnused   = 2'd3;

  // wiring table select codes
  localparam logic [1:0] SelRight     = 2'd0;
  localparam logic [1:0] SelMiddle    = 2'd1;
  localparam logic [1:0] SelLeft      = 2'd2;
  localparam logic [1:0] SelReflector = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CfgLeftStart   = 3'd0;
  localparam logic [2:0] CfgMiddleStart = 3'd1;
  localparam logic [2:0] CfgRightStart  = 3'd2;
  localparam logic [2:0] CfgLeftNotch   = 3'd3;
  localparam logic [2:0] CfgMiddleNotch = 3'd4;
  localparam logic [2:0] CfgRightNotch  = 3'd5;

  // configuration reset values
  localparam logic [4:0] RstStart       = 5'd0;
  localparam logic [4:0] RstLeftNotch   = 5'd17;
  localparam logic [4:0] RstMiddleNotch = 5'd5;
  localparam logic [4:0] RstRightNotch  = 5'd22;

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7A;

  typedef logic [4:0] letter_t;

  // (a + b) mod 26 for a, b below 26
  function automatic letter_t add26(input letter_t a, input letter_t b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 6'(NumLetters)) begin
      s = s - 6'(NumLetters);
    end
    return s[4:0];
  endfunction

  // (a - b) mod 26 for a, b below 26
  function automatic letter_t sub26(input letter_t a, input letter_t b);
    logic [5:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (a < b) begin
      d = d + 6'(NumLetters);
    end
    return d[4:0];
  endfunction

  // reduce a 5-bit value mod 26
  function automatic letter_t mod26(input letter_t a);
    return (a > LastLetter) ? 5'(a - 5'(NumLetters)) : a;
  endfunction

endpackage

### src/rotor_cipher_byte.sv
// Three-rotor byte cipher: letters enciphered with case kept, other bytes pass.
// A result passes through the stage register, then the output register.
// Throughput: one item per cycle while the output is taken; stepping is combinational.
// Reset (rst, synchronous): start regs 0, notches 17/5/22, rotor positions 0,
// pipeline and output empty. Wiring tables are not cleared; load them before use.
module rotor_cipher_byte (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [4:0]           cfg_data,
  // input item channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           func,
  input  logic [7:0]           data_byte,
  input  logic [1:0]           table_sel,
  input  logic [4:0]           table_index,
  input  logic [4:0]           table_value,
  // result item channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte
);
  import rcb_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers; the port never stalls.
  // ---------------------------------------------------------------------
  letter_t left_start, middle_start, right_start;
  letter_t left_notch, middle_notch, right_notch;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_start   <= RstStart;
      middle_start <= RstStart;
      right_start  <= RstStart;
      left_notch   <= RstLeftNotch;
      middle_notch <= RstMiddleNotch;
      right_notch  <= RstRightNotch;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CfgLeftStart:   left_start   <= cfg_data;
        CfgMiddleStart: middle_start <= cfg_data;
        CfgRightStart:  right_start  <= cfg_data;
        CfgLeftNotch:   left_notch   <= cfg_data;
        CfgMiddleNotch: middle_notch <= cfg_data;
        CfgRightNotch:  right_notch  <= cfg_data;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage register: holds an encipher item with its stepped rotor
  // positions, or a wiring load. Loads are written to the tables as they
  // leave this stage, so an encipher item here always sees every earlier
  // load and none after it.
  // ---------------------------------------------------------------------
  logic       s1_valid;
  logic       s1_enc;        // encipher item, else table load
  logic       s1_letter;     // byte is an ASCII letter
  logic [7:0] s1_byte;       // raw byte, for pass-through
  logic [7:0] s1_base;       // 'A' or 'a'
  letter_t    s1_code;
  letter_t    s1_l, s1_m, s1_r;
  logic [1:0] s1_sel;
  letter_t    s1_idx, s1_val;

  logic s1_adv;
  logic in_fire;

  // a load never waits on the output; an encipher item needs a free slot
  assign s1_adv   = !s1_enc || !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;
  assign in_fire  = in_valid && in_ready;

  // ---------------------------------------------------------------------
  // Rotor positions. They step as an encipher letter is accepted and reload
  // on a restart, so the next item sees the advanced state right away.
  // ---------------------------------------------------------------------
  letter_t left_pos, middle_pos, right_pos;
  letter_t left_pos_next, middle_pos_next, right_pos_next;
  letter_t r_step, m_step;

  logic is_upper, is_lower, load_ok;

  assign is_upper = (data_byte >= CharUpperA) && (data_byte <= CharUpperZ);
  assign is_lower = (data_byte >= CharLowerA) && (data_byte <= CharLowerZ);
  assign load_ok  = (table_index <= LastLetter) && (table_value <= LastLetter);

  always_comb begin
    r_step          = add26(right_pos, 5'd1);
    m_step          = add26(middle_pos, 5'd1);
    left_pos_next   = left_pos;
    middle_pos_next = middle_pos;
    right_pos_next  = right_pos;
    if (in_fire) begin
      unique case (func)
        FuncEncipher: begin
          // only letters step the rotors; no double-step
          if (is_upper || is_lower) begin
            right_pos_next = r_step;
            if (r_step == right_notch) begin
              middle_pos_next = m_step;
              if (m_step == middle_notch) begin
                left_pos_next = add26(left_pos, 5'd1);
              end
            end
          end
        end
        FuncRestart: begin
          left_pos_next   = mod26(left_start);
          middle_pos_next = mod26(middle_start);
          right_pos_next  = mod26(right_start);
        end
        FuncLoad, FuncUnused: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pos   <= RstStart;
      middle_pos <= RstStart;
      right_pos  <= RstStart;
    end else begin
      left_pos   <= left_pos_next;
      middle_pos <= middle_pos_next;
      right_pos  <= right_pos_next;
    end
  end

  // stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      // restart, unused func and rejected loads leave nothing behind
      s1_valid <= in_fire && ((func == FuncEncipher) || ((func == FuncLoad) && load_ok));
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_enc    <= (func == FuncEncipher);
      s1_letter <= is_upper || is_lower;
      s1_byte   <= data_byte;
      s1_base   <= is_upper ? CharUpperA : CharLowerA;
      s1_code   <= is_upper ? 5'(data_byte - CharUpperA) : 5'(data_byte - CharLowerA);
      s1_l      <= left_pos_next;
      s1_m      <= middle_pos_next;
      s1_r      <= right_pos_next;
      s1_sel    <= table_sel;
      s1_idx    <= table_index;
      s1_val    <= table_value;
    end
  end

  // ---------------------------------------------------------------------
  // Wiring tables, 26 x 5 bits each, in flops. Each forward load also
  // writes the inverse entry; the reflector has no inverse.
  // ---------------------------------------------------------------------
  letter_t right_wiring     [NumLetters];
  letter_t middle_wiring    [NumLetters];
  letter_t left_wiring      [NumLetters];
  letter_t reflector_wiring [NumLetters];
  letter_t right_inverse    [NumLetters];
  letter_t middle_inverse   [NumLetters];
  letter_t left_inverse     [NumLetters];

  always_ff @(posedge clk) begin
    if (s1_valid && !s1_enc && s1_adv) begin
      unique case (s1_sel)
        SelRight: begin
          right_wiring[s1_idx]  <= s1_val;
          right_inverse[s1_val] <= s1_idx;
        end
        SelMiddle: begin
          middle_wiring[s1_idx]  <= s1_val;
          middle_inverse[s1_val] <= s1_idx;
        end
        SelLeft: begin
          left_wiring[s1_idx]  <= s1_val;
          left_inverse[s1_val] <= s1_idx;
        end
        SelReflector: reflector_wiring[s1_idx] <= s1_val;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Signal path: forward through the rotors, reflector, then back through
  // the inverse wirings. Offsets are relative positions between rotors.
  // ---------------------------------------------------------------------
  letter_t off_mr, off_lm;
  letter_t x0, x1, x2, x3, x4, x5, x6, res;
  logic [7:0] enc_byte;

  always_comb begin
    off_mr   = sub26(s1_m, s1_r);
    off_lm   = sub26(s1_l, s1_m);
    x0       = right_wiring[add26(s1_r, s1_code)];
    x1       = middle_wiring[add26(x0, off_mr)];
    x2       = left_wiring[add26(x1, off_lm)];
    x3       = reflector_wiring[sub26(x2, s1_l)];
    x4       = left_inverse[add26(x3, s1_l)];
    x5       = middle_inverse[sub26(x4, off_lm)];
    x6       = right_inverse[sub26(x5, off_mr)];
    res      = sub26(x6, s1_r);
    enc_byte = s1_letter ? (s1_base + {3'b000, res}) : s1_byte;
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_enc && s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_enc && s1_adv) begin
      out_byte <= enc_byte;
    end
  end

endmodule

### sim/tb.sv
module tb;
  import rcb_pkg::*;

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------
  localparam int AlphaLen    = int'(NumLetters);
  localparam int SettleCycles = 6;       // results pass the stage and output registers, loads/restarts give none
  localparam int CycleLimit  = 100000;   // generous watchdog for ~520 items
  localparam int StallCycles = 80;       // long receiver hold-off to back up the pipe

  typedef struct packed {
    logic [1:0] fn;
    logic [7:0] data;
    logic [1:0] sel;
    logic [4:0] idx;
    logic [4:0] val;
  } cipher_item_t;

  // ---------------------------------------------------------------------------
  // DUT signals; the inputs are all known from time zero
  // ---------------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [4:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] func = FuncEncipher;
  logic [7:0] data_byte = '0;
  logic [1:0] table_sel = SelRight;
  logic [4:0] table_index = '0;
  logic [4:0] table_value = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;

  rotor_cipher_byte u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .data_byte  (data_byte),
    .table_sel  (table_sel),
    .table_index(table_index),
    .table_value(table_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the cipher: registers, rotor positions, wiring and inverses.
  // Tables are indexed by the select code (right, middle, left, reflector).
  // ---------------------------------------------------------------------------
  logic [4:0]   cfg_shadow [6];
  letter_t      rotor_pos  [3];
  letter_t      fwd_tab    [4][26];
  letter_t      inv_tab    [3][26];

  cipher_item_t item_q   [$];   // items waiting to be offered
  logic [7:0]   cipher_q [$];   // predicted out_byte values, oldest first

  int unsigned  cycle_cnt   = 0;
  int unsigned  items_taken = 0;
  int unsigned  errors      = 0;
  int unsigned  in_idle_pct  = 23;
  int unsigned  out_idle_pct = 23;
  int unsigned  stall_at     = 32'hFFFF_FFFF;
  logic         stall_done   = 1'b0;
  int unsigned  hold_left    = 0;
  int           perm [26];

  function automatic int wrap26(input int v);
    return ((v % AlphaLen) + AlphaLen) % AlphaLen;
  endfunction

  function automatic letter_t advance(input letter_t p);
    return letter_t'(wrap26(int'(p) + 1));
  endfunction

  // Step the rotors, then run letter code c through the forward path,
  // the reflector and back through the inverse path.
  function automatic int rotor_path(input int c);
    int l, m, r, x;
    rotor_pos[SelRight] = advance(rotor_pos[SelRight]);
    // no double-step: middle only moves when right lands on its notch
    if (rotor_pos[SelRight] == cfg_shadow[CfgRightNotch]) begin
      rotor_pos[SelMiddle] = advance(rotor_pos[SelMiddle]);
      if (rotor_pos[SelMiddle] == cfg_shadow[CfgMiddleNotch]) begin
        rotor_pos[SelLeft] = advance(rotor_pos[SelLeft]);
      end
    end
    l = int'(rotor_pos[SelLeft]);
    m = int'(rotor_pos[SelMiddle]);
    r = int'(rotor_pos[SelRight]);
    x = int'(fwd_tab[SelRight][wrap26(r + c)]);
    x = int'(fwd_tab[SelMiddle][wrap26(x + m - r)]);
    x = int'(fwd_tab[SelLeft][wrap26(x + l - m)]);
    x = int'(fwd_tab[SelReflector][wrap26(x - l)]);
    x = int'(inv_tab[SelLeft][wrap26(x + l)]);
    x = int'(inv_tab[SelMiddle][wrap26(x - l + m)]);
    x = int'(inv_tab[SelRight][wrap26(x - m + r)]);
    return wrap26(x - r);
  endfunction

  // Case is kept; anything outside A-Z / a-z passes through untouched.
  function automatic logic [7:0] cipher_byte(input logic [7:0] b);
    if (b >= CharUpperA && b <= CharUpperZ) begin
      return CharUpperA + 8'(rotor_path(int'(b - CharUpperA)));
    end else if (b >= CharLowerA && b <= CharLowerZ) begin
      return CharLowerA + 8'(rotor_path(int'(b - CharLowerA)));
    end
    return b;
  endfunction

  // Apply one accepted item to the shadow and queue its result, if any.
  task automatic track_item(input cipher_item_t it);
    case (it.fn)
      FuncEncipher: begin
        cipher_q.push_back(cipher_byte(it.data));
      end
      FuncLoad: begin
        // out-of-range index or value: whole load dropped
        if (it.idx <= LastLetter && it.val <= LastLetter) begin
          fwd_tab[it.sel][it.idx] = it.val;
          // reflector has no inverse table
          if (it.sel != SelReflector) begin
            inv_tab[it.sel][it.val] = it.idx;
          end
        end
      end
      FuncRestart: begin
        rotor_pos[SelLeft]   = letter_t'(wrap26(int'(cfg_shadow[CfgLeftStart])));
        rotor_pos[SelMiddle] = letter_t'(wrap26(int'(cfg_shadow[CfgMiddleStart])));
        rotor_pos[SelRight]  = letter_t'(wrap26(int'(cfg_shadow[CfgRightStart])));
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0d] mismatch: %s", cycle_cnt, what);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic [1:0] fn, input logic [7:0] data,
                           input logic [1:0] sel, input logic [4:0] idx,
                           input logic [4:0] val);
    cipher_item_t it;
    it.fn = fn; it.data = data; it.sel = sel; it.idx = idx; it.val = val;
    item_q.push_back(it);
  endtask

  task automatic push_letter(input logic [7:0] ch);
    push_item(FuncEncipher, ch, 2'($urandom_range(3)), 5'($urandom_range(31)),
              5'($urandom_range(31)));
  endtask

  task automatic shuffle_letters();
    int j, t;
    for (int i = 0; i < AlphaLen; i++) perm[i] = i;
    for (int i = AlphaLen - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = perm[i]; perm[i] = perm[j]; perm[j] = t;
    end
  endtask

  // Full wiring for every table so no unwritten entry is ever read later.
  task automatic push_full_wiring();
    int a, b;
    for (int s = SelRight; s <= SelLeft; s++) begin
      shuffle_letters();
      for (int i = 0; i < AlphaLen; i++) begin
        push_item(FuncLoad, 8'($urandom_range(255)), 2'(s), 5'(i), 5'(perm[i]));
      end
    end
    // reflector as pairwise swaps, like the real thing
    shuffle_letters();
    for (int k = 0; k < AlphaLen / 2; k++) begin
      a = perm[2 * k];
      b = perm[2 * k + 1];
      push_item(FuncLoad, 8'($urandom_range(255)), SelReflector, 5'(a), 5'(b));
      push_item(FuncLoad, 8'($urandom_range(255)), SelReflector, 5'(b), 5'(a));
    end
  endtask

  // Mostly letters so the rotors turn over; some loads, restarts and noise.
  task automatic push_random_item();
    int pick;
    logic [4:0] idx;
    logic [4:0] val;
    pick = $urandom_range(99);
    if (pick < 70) begin
      push_letter(($urandom_range(1) ? CharUpperA : CharLowerA) + 8'($urandom_range(25)));
    end else if (pick < 78) begin
      push_letter(8'($urandom_range(255)));
    end else if (pick < 88) begin
      push_item(FuncLoad, 8'($urandom_range(255)), 2'($urandom_range(3)),
                5'($urandom_range(25)), 5'($urandom_range(25)));
    end else if (pick < 92) begin
      // malformed load: index and/or value past the alphabet
      idx = 5'($urandom_range(31));
      val = (idx > LastLetter) ? 5'($urandom_range(31)) : 5'(26 + $urandom_range(5));
      push_item(FuncLoad, 8'($urandom_range(255)), 2'($urandom_range(3)), idx, val);
    end else if (pick < 97) begin
      push_item(FuncRestart, 8'($urandom_range(255)), 2'($urandom_range(3)),
                5'($urandom_range(31)), 5'($urandom_range(31)));
    end else begin
      push_item(FuncUnused, 8'($urandom_range(255)), 2'($urandom_range(3)),
                5'($urandom_range(31)), 5'($urandom_range(31)));
    end
  endtask

  // Sender holds off until every queued item is in and every result is out,
  // then lets loads/restarts still in flight settle.
  task automatic wait_drained();
    while (item_q.size() != 0 || in_valid || cipher_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Leaves cfg_valid high; caller drops it after the last write of a batch.
  task automatic write_cfg(input logic [2:0] idx, input logic [4:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_shadow[idx] = val;
  endtask

  task automatic write_all_cfg(input logic [4:0] ls, input logic [4:0] ms,
                               input logic [4:0] rs, input logic [4:0] ln,
                               input logic [4:0] mn, input logic [4:0] rn);
    write_cfg(CfgLeftStart, ls);
    write_cfg(CfgMiddleStart, ms);
    write_cfg(CfgRightStart, rs);
    write_cfg(CfgLeftNotch, ln);
    write_cfg(CfgMiddleNotch, mn);
    write_cfg(CfgRightNotch, rn);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: offers items from item_q, idles at random, updates the
  // shadow on each handshake.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_items
    cipher_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        nxt.fn = func; nxt.data = data_byte; nxt.sel = table_sel;
        nxt.idx = table_index; nxt.val = table_value;
        track_item(nxt);
        items_taken <= items_taken + 1;
      end
      // payload only moves once the current item is gone
      if (!in_valid || in_ready) begin
        if (item_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          nxt = item_q.pop_front();
          in_valid    <= 1'b1;
          func        <= nxt.fn;
          data_byte   <= nxt.data;
          table_sel   <= nxt.sel;
          table_index <= nxt.idx;
          table_value <= nxt.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: checks each result against the oldest prediction and
  // throttles out_ready, with one long hold-off to back up the pipe.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_results
    logic [7:0] want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (cipher_q.size() == 0) begin
          report_mismatch($sformatf("unexpected out_byte 0x%02h", out_byte));
        end else begin
          want = cipher_q.pop_front();
          if (out_byte !== want) begin
            report_mismatch($sformatf("out_byte 0x%02h, predicted 0x%02h", out_byte, want));
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!stall_done && items_taken >= stall_at) begin
        hold_left  <= StallCycles;
        stall_done <= 1'b1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("rotor_cipher_byte verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------------------
  initial begin
    cfg_shadow[CfgLeftStart]   = RstStart;
    cfg_shadow[CfgMiddleStart] = RstStart;
    cfg_shadow[CfgRightStart]  = RstStart;
    cfg_shadow[CfgLeftNotch]   = RstLeftNotch;
    cfg_shadow[CfgMiddleNotch] = RstMiddleNotch;
    cfg_shadow[CfgRightNotch]  = RstRightNotch;
    for (int s = 0; s < 3; s++) rotor_pos[s] = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- phase 0: reset register values ---
    // pass-through bytes at the extremes and just outside the letter ranges; tables not loaded yet
    push_letter(8'h00);
    push_letter(8'hFF);
    push_letter(CharUpperA - 8'd1);
    push_letter(CharUpperZ + 8'd1);
    push_letter(CharLowerA - 8'd1);
    push_letter(CharLowerZ + 8'd1);
    // unused function code, all fields high
    push_item(FuncUnused, 8'hFF, SelReflector, 5'd31, 5'd31);
    // loads that must be dropped
    push_item(FuncLoad, 8'h00, SelRight, 5'd26, 5'd0);
    push_item(FuncLoad, 8'hFF, SelLeft, 5'd31, 5'd31);
    push_item(FuncLoad, 8'h55, SelMiddle, 5'd3, 5'd26);
    push_item(FuncLoad, 8'hAA, SelReflector, 5'd0, 5'd31);
    push_item(FuncRestart, 8'h00, SelRight, 5'd0, 5'd0);
    push_full_wiring();
    // alphabet edges, both cases
    push_letter(CharUpperA);
    push_letter(CharUpperZ);
    push_letter(CharLowerA);
    push_letter(CharLowerZ);
    // duplicate value in the middle rotor: inverse tracks the newest index
    push_item(FuncLoad, 8'h00, SelMiddle, 5'd0, 5'd25);
    push_item(FuncLoad, 8'h00, SelMiddle, 5'd1, 5'd25);
    // walk the right rotor across its reset notch
    for (int i = 0; i < 24; i++) push_letter(CharUpperA + 8'(i));
    for (int i = 0; i < 70; i++) push_random_item();
    wait_drained();

    // --- phase 1: right rotor one short of its notch, left wraps at once ---
    // no idling on either side for a long clean stretch
    write_all_cfg(5'd25, 5'd4, 5'd21, 5'd0, 5'd5, 5'd22);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    push_item(FuncRestart, 8'h00, SelRight, 5'd0, 5'd0);
    for (int i = 0; i < 100; i++) push_random_item();
    wait_drained();

    // --- phase 2: out-of-range starts fold mod 26, right notch never matches ---
    write_all_cfg(5'd31, 5'd31, 5'd31, 5'd31, 5'd0, 5'd31);
    in_idle_pct  = 23;
    out_idle_pct = 23;
    push_item(FuncRestart, 8'hFF, SelReflector, 5'd31, 5'd31);
    for (int i = 0; i < 80; i++) push_random_item();
    wait_drained();

    // --- phase 3: middle and right notches at zero, starts at the top; long receiver stall ---
    write_all_cfg(5'd25, 5'd25, 5'd25, 5'd25, 5'd0, 5'd0);
    stall_at = items_taken + 30;
    push_item(FuncRestart, 8'h00, SelLeft, 5'd0, 5'd0);
    for (int i = 0; i < 120; i++) push_random_item();

    // drain, bounded so a lost result shows up as a leftover
    while (item_q.size() != 0 || in_valid) @(posedge clk);
    for (int k = 0; k < 2000 && cipher_q.size() != 0; k++) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (cipher_q.size() != 0) begin
      report_mismatch($sformatf("%0d predicted results never arrived", cipher_q.size()));
    end

    if (errors == 0) begin
      $display("rotor_cipher_byte verification clean");
    end else begin
      $display("rotor_cipher_byte verification failed");
    end
    $finish;
  end

endmodule

### sim.f
src/rcb_pkg.sv
src/rotor_cipher_byte.sv
sim/tb.sv
